// File: sv/fit_pkg.sv
// ----------------------------------------------------------------------------
// fit_pkg
// Types and constants shared by the frame index tracker modules.
// ----------------------------------------------------------------------------
package fit_pkg;

  localparam int STATUS_W     = 3;
  localparam int WORD_W       = 16;
  localparam int IN_TDATA_W   = 56;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_TUSER_W  = 3;

  typedef enum logic [1:0] {
    ACT_ALLOC,
    ACT_SET,
    ACT_TX,
    ACT_POLL
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_EMPTY,
    ST_ALLOC,
    ST_TX,
    ST_RCVD,
    ST_COMPLETE
  } status_t;

  typedef enum logic [2:0] {
    K_INDEX,
    K_DONE,
    K_WKC,
    K_NOFRAME,
    K_OTHER
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_PUSH
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [WORD_W-1:0]   value;
    logic [WORD_W-1:0]   route_word;
  } result_t;

endpackage

// File: sv/fit_stat_mem.sv
// ----------------------------------------------------------------------------
// fit_stat_mem
// Slot status memory: one write port, two registered read ports, per-entry
// valid bits so that unwritten entries read as empty after reset.
// ----------------------------------------------------------------------------
module fit_stat_mem #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [fit_pkg::STATUS_W-1:0]  wdata,
  input  logic [AW-1:0]                 raddr_a,
  output logic [fit_pkg::STATUS_W-1:0]  rdata_a,
  input  logic [AW-1:0]                 raddr_b,
  output logic [fit_pkg::STATUS_W-1:0]  rdata_b
);

  logic [fit_pkg::STATUS_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]             vld;
  logic [fit_pkg::STATUS_W-1:0] q_a;
  logic [fit_pkg::STATUS_W-1:0] q_b;
  logic                         vq_a;
  logic                         vq_b;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_a <= mem[raddr_a];
    q_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      vq_a <= 1'b0;
      vq_b <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      vq_a <= vld[raddr_a];
      vq_b <= vld[raddr_b];
    end
  end

  assign rdata_a = vq_a ? q_a : fit_pkg::ST_EMPTY;
  assign rdata_b = vq_b ? q_b : fit_pkg::ST_EMPTY;

endmodule

// File: sv/fit_data_mem.sv
// ----------------------------------------------------------------------------
// fit_data_mem
// Working counter and source word store, one write and one registered read
// port. Contents are undefined until written.
// ----------------------------------------------------------------------------
module fit_data_mem #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic [2*fit_pkg::WORD_W-1:0]    wdata,
  input  logic [AW-1:0]                   raddr,
  output logic [2*fit_pkg::WORD_W-1:0]    rdata
);

  logic [2*fit_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/fit_ctrl.sv
// ----------------------------------------------------------------------------
// fit_ctrl
// Sequencer: takes one beat, reads the status and data memories, runs the
// round-robin free-slot scan, writes back and holds the result beat.
// ----------------------------------------------------------------------------
module fit_ctrl #(
  parameter int MAX_FRAMES = 16,
  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [fit_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [fit_pkg::IN_TUSER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [fit_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic [fit_pkg::OUT_TUSER_W-1:0]    m_tuser,
  output logic                               st_we,
  output logic [IW-1:0]                      st_waddr,
  output logic [fit_pkg::STATUS_W-1:0]       st_wdata,
  output logic [IW-1:0]                      st_raddr_a,
  input  logic [fit_pkg::STATUS_W-1:0]       st_rdata_a,
  output logic [IW-1:0]                      st_raddr_b,
  input  logic [fit_pkg::STATUS_W-1:0]       st_rdata_b,
  output logic                               dm_we,
  output logic [IW-1:0]                      dm_waddr,
  output logic [2*fit_pkg::WORD_W-1:0]       dm_wdata,
  output logic [IW-1:0]                      dm_raddr,
  input  logic [2*fit_pkg::WORD_W-1:0]       dm_rdata
);

  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_FRAMES - 1);
  localparam logic [8:0]    DEPTH_9  = 9'(MAX_FRAMES);

  fit_pkg::state_t  state;
  fit_pkg::state_t  state_next;
  fit_pkg::action_t act;
  logic [3:0]       slot;
  logic [2:0]       nstat;
  logic             failed;
  logic             present;
  logic             is_ecat;
  logic [7:0]       fidx;
  logic [15:0]      fwkc;
  logic [15:0]      fsrc;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    idx_next;
  logic [IW-1:0]    cnt;
  logic [IW-1:0]    cnt_next;
  logic [IW-1:0]    last;
  logic [IW-1:0]    last_next;
  fit_pkg::result_t res;
  fit_pkg::result_t res_next;
  fit_pkg::result_t out;
  logic             out_load;

  logic             slot_in_range;
  logic             fidx_in_range;
  logic [IW-1:0]    slot_addr;
  logic [IW-1:0]    fidx_addr;
  logic [IW-1:0]    idx_succ;
  logic [IW-1:0]    pick;

  function automatic logic [IW-1:0] succ(input logic [IW-1:0] i);
    succ = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign slot_in_range = {5'd0, slot} < DEPTH_9;
  assign fidx_in_range = {1'b0, fidx} < DEPTH_9;
  assign slot_addr     = IW'(slot);
  assign fidx_addr     = IW'(fidx);
  assign idx_succ      = succ(idx);
  assign pick          = (st_rdata_a == fit_pkg::ST_EMPTY) ? idx : idx_succ;

  // input beat capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act     <= fit_pkg::action_t'(s_tuser[1:0]);
      slot    <= s_tdata[3:0];
      nstat   <= s_tdata[6:4];
      failed  <= s_tdata[7];
      present <= s_tdata[8];
      is_ecat <= s_tdata[9];
      fidx    <= s_tdata[17:10];
      fwkc    <= s_tdata[33:18];
      fsrc    <= s_tdata[49:34];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fit_pkg::S_IDLE;
      last  <= '0;
    end else begin
      state <= state_next;
      last  <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    cnt <= cnt_next;
    res <= res_next;
  end

  // writes only happen in S_EXEC
  always_comb begin
    state_next = state;
    idx_next   = idx;
    cnt_next   = cnt;
    last_next  = last;
    res_next   = res;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    st_we      = 1'b0;
    st_waddr   = slot_addr;
    st_wdata   = nstat;
    st_raddr_a = slot_addr;
    st_raddr_b = fidx_addr;
    dm_we      = 1'b0;
    dm_waddr   = slot_addr;
    dm_wdata   = {fsrc, fwkc};
    dm_raddr   = slot_addr;
    unique case (state)
      fit_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          idx_next   = succ(last);
          cnt_next   = '0;
          state_next = fit_pkg::S_READ;
        end
      end
      fit_pkg::S_READ: begin
        if (act == fit_pkg::ACT_ALLOC) begin
          st_raddr_a = idx;
        end
        state_next = fit_pkg::S_EXEC;
      end
      fit_pkg::S_EXEC: begin
        unique case (act)
          fit_pkg::ACT_ALLOC: begin
            if (st_rdata_a == fit_pkg::ST_EMPTY || cnt == LAST_IDX) begin
              st_we      = 1'b1;
              st_waddr   = pick;
              st_wdata   = fit_pkg::ST_ALLOC;
              last_next  = pick;
              res_next   = '{kind: fit_pkg::K_INDEX, value: 16'(pick), route_word: '0};
              state_next = fit_pkg::S_PUSH;
            end else begin
              // one probe per cycle, next entry read ahead
              st_raddr_a = idx_succ;
              idx_next   = idx_succ;
              cnt_next   = cnt + 1'b1;
            end
          end
          fit_pkg::ACT_SET: begin
            st_we      = slot_in_range;
            st_wdata   = nstat;
            res_next   = '{kind: fit_pkg::K_DONE, value: '0, route_word: '0};
            state_next = fit_pkg::S_PUSH;
          end
          fit_pkg::ACT_TX: begin
            st_we      = slot_in_range;
            st_wdata   = failed ? fit_pkg::ST_EMPTY : fit_pkg::ST_TX;
            res_next   = '{kind: fit_pkg::K_DONE, value: '0, route_word: '0};
            state_next = fit_pkg::S_PUSH;
          end
          fit_pkg::ACT_POLL: begin
            state_next = fit_pkg::S_PUSH;
            res_next   = '{kind: fit_pkg::K_OTHER, value: '0, route_word: '0};
            priority if (slot_in_range && st_rdata_a == fit_pkg::ST_RCVD) begin
              st_we    = 1'b1;
              st_wdata = fit_pkg::ST_COMPLETE;
              res_next = '{kind: fit_pkg::K_WKC, value: dm_rdata[15:0],
                           route_word: dm_rdata[31:16]};
            end else if (!present) begin
              res_next = '{kind: fit_pkg::K_NOFRAME, value: '0, route_word: '0};
            end else if (!is_ecat) begin
              res_next = '{kind: fit_pkg::K_OTHER, value: '0, route_word: '0};
            end else if (slot_in_range && fidx == {4'd0, slot}) begin
              st_we    = 1'b1;
              st_wdata = fit_pkg::ST_COMPLETE;
              dm_we    = 1'b1;
              res_next = '{kind: fit_pkg::K_WKC, value: fwkc, route_word: fsrc};
            end else if (fidx_in_range && st_rdata_b == fit_pkg::ST_TX) begin
              st_we    = 1'b1;
              st_waddr = fidx_addr;
              st_wdata = fit_pkg::ST_RCVD;
              dm_we    = 1'b1;
              dm_waddr = fidx_addr;
            end else begin
              res_next = '{kind: fit_pkg::K_OTHER, value: '0, route_word: '0};
            end
          end
          default: begin
            state_next = fit_pkg::S_IDLE;
          end
        endcase
      end
      fit_pkg::S_PUSH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = fit_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fit_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out <= res;
    end
  end

  assign m_tdata = {out.route_word, out.value};
  assign m_tuser = out.kind;

endmodule

// File: sv/frame_index_tracker.sv
// ----------------------------------------------------------------------------
// frame_index_tracker
// In-flight frame index tracker with round-robin allocation and frame match.
// ----------------------------------------------------------------------------
// One beat is worked at a time. Set status, transmit and poll pass through
// the read, execute and push states; allocate stays in the execute state
// for the free-slot scan, which probes one status memory entry per cycle
// through a single read port. Slot status lives in a memory with per-entry
// valid bits cleared by reset, so the block is usable straight after reset.
// Working counters and source words live in a second memory and are
// undefined until written. A finished result waits in an output register
// while the next input beat is taken.
// ----------------------------------------------------------------------------
module frame_index_tracker #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // slot[3:0] new_status[6:4] send_failed[7] frame_present[8]
  // frame_is_ecat[9] frame_index[17:10] frame_wkc[33:18] frame_source[49:34]
  input  logic [fit_pkg::IN_TDATA_W-1:0]     s_tdata,
  // action[1:0]
  input  logic [fit_pkg::IN_TUSER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // value[15:0] route_word[31:16]
  output logic [fit_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // kind[2:0]
  output logic [fit_pkg::OUT_TUSER_W-1:0]    m_tuser
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic                           st_we;
  logic [IW-1:0]                  st_waddr;
  logic [fit_pkg::STATUS_W-1:0]   st_wdata;
  logic [IW-1:0]                  st_raddr_a;
  logic [fit_pkg::STATUS_W-1:0]   st_rdata_a;
  logic [IW-1:0]                  st_raddr_b;
  logic [fit_pkg::STATUS_W-1:0]   st_rdata_b;
  logic                           dm_we;
  logic [IW-1:0]                  dm_waddr;
  logic [2*fit_pkg::WORD_W-1:0]   dm_wdata;
  logic [IW-1:0]                  dm_raddr;
  logic [2*fit_pkg::WORD_W-1:0]   dm_rdata;

  fit_stat_mem #(
    .DEPTH (MAX_FRAMES)
  ) u_stat_mem (
    .clk     (clk),
    .rst     (rst),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr_a (st_raddr_a),
    .rdata_a (st_rdata_a),
    .raddr_b (st_raddr_b),
    .rdata_b (st_rdata_b)
  );

  fit_data_mem #(
    .DEPTH (MAX_FRAMES)
  ) u_data_mem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  fit_ctrl #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata),
    .st_raddr_a (st_raddr_a),
    .st_rdata_a (st_rdata_a),
    .st_raddr_b (st_raddr_b),
    .st_rdata_b (st_rdata_b),
    .dm_we      (dm_we),
    .dm_waddr   (dm_waddr),
    .dm_wdata   (dm_wdata),
    .dm_raddr   (dm_raddr),
    .dm_rdata   (dm_rdata)
  );

endmodule

// File: tb/frame_index_tracker_test.sv
// ----------------------------------------------------------------------------
// frame_index_tracker_test
// Self-checking bench for the frame index tracker. A driver feeds request
// beats from a queue with random gaps, a monitor predicts each accepted beat
// against its own copy of the slot table and checks every result beat in
// order. Directed beats cover a full table, odd status codes, failed sends,
// early receive and dropped frames; random sequences then allocate, send and
// poll with well-formed and malformed frames.
// ----------------------------------------------------------------------------
module frame_index_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 40;
  localparam int IDLE_PCT    = 23;

  typedef struct packed {
    fit_pkg::action_t act;
    logic [3:0]       slot;
    logic [2:0]       nstat;
    logic             fail;
    logic             present;
    logic             ecat;
    logic [7:0]       fidx;
    logic [15:0]      fwkc;
    logic [15:0]      fsrc;
  } req_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [fit_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic [fit_pkg::IN_TUSER_W-1:0]  s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [fit_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [fit_pkg::OUT_TUSER_W-1:0] m_tuser;

  frame_index_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted slot table
  logic [2:0]  slot_state [SLOTS];
  logic [15:0] slot_count [SLOTS];
  logic [15:0] slot_mac   [SLOTS];
  logic [3:0]  last_granted;

  // generator side: slots whose counter store has been written
  logic        count_known [SLOTS];

  req_t              pending_beats [$];
  fit_pkg::result_t  due_results [$];
  req_t              in_hand;
  logic              beat_taken = 1'b0;
  int                queued_cnt = 0;
  int                taken_cnt = 0;
  int                checked_cnt = 0;
  int                errors = 0;
  int                stall_cycles = 0;
  int                cycle_no = 0;
  int                kind_seen [5];
  logic              steady;

  assign steady = (cycle_no >= 3000) && (cycle_no < 4500);

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch in %s at result %0d: got %h, expected %h",
             what, checked_cnt, got, want);
    errors++;
  endtask

  function automatic void forecast(input req_t rq, output fit_pkg::result_t res);
    logic [3:0] idx;
    int         tries;
    res.kind = fit_pkg::K_DONE;
    res.value = '0;
    res.route_word = '0;
    unique case (rq.act)
      fit_pkg::ACT_ALLOC: begin
        idx = last_granted + 4'd1;
        tries = 0;
        while (slot_state[idx] != fit_pkg::ST_EMPTY && tries < SLOTS) begin
          idx++;
          tries++;
        end
        slot_state[idx] = fit_pkg::ST_ALLOC;
        last_granted = idx;
        res.kind = fit_pkg::K_INDEX;
        res.value = {12'd0, idx};
      end
      fit_pkg::ACT_SET: slot_state[rq.slot] = rq.nstat;
      fit_pkg::ACT_TX: slot_state[rq.slot] = rq.fail ? fit_pkg::ST_EMPTY : fit_pkg::ST_TX;
      default: begin
        if (slot_state[rq.slot] == fit_pkg::ST_RCVD) begin
          res.kind = fit_pkg::K_WKC;
          res.value = slot_count[rq.slot];
          res.route_word = slot_mac[rq.slot];
          slot_state[rq.slot] = fit_pkg::ST_COMPLETE;
        end else if (!rq.present) begin
          res.kind = fit_pkg::K_NOFRAME;
        end else begin
          res.kind = fit_pkg::K_OTHER;
          if (rq.ecat) begin
            if (rq.fidx == {4'd0, rq.slot}) begin
              res.kind = fit_pkg::K_WKC;
              res.value = rq.fwkc;
              res.route_word = rq.fsrc;
              slot_count[rq.slot] = rq.fwkc;
              slot_mac[rq.slot] = rq.fsrc;
              slot_state[rq.slot] = fit_pkg::ST_COMPLETE;
            end else if (rq.fidx[7:4] == 4'd0 &&
                         slot_state[rq.fidx[3:0]] == fit_pkg::ST_TX) begin
              slot_count[rq.fidx[3:0]] = rq.fwkc;
              slot_mac[rq.fidx[3:0]] = rq.fsrc;
              slot_state[rq.fidx[3:0]] = fit_pkg::ST_RCVD;
            end
          end
        end
      end
    endcase
  endfunction

  function automatic req_t random_req();
    req_t rq;
    rq.act = fit_pkg::action_t'($urandom_range(0, 3));
    rq.slot = 4'($urandom_range(0, 15));
    rq.nstat = 3'($urandom_range(0, 7));
    rq.fail = 1'($urandom);
    rq.present = 1'($urandom);
    rq.ecat = 1'($urandom);
    rq.fidx = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    rq.fwkc = 16'($urandom);
    rq.fsrc = 16'($urandom);
    return rq;
  endfunction

  // a received status is only set where the counter store holds a value
  task automatic queue_beat(input req_t rq);
    if (rq.act == fit_pkg::ACT_SET && rq.nstat == fit_pkg::ST_RCVD && !count_known[rq.slot])
      rq.nstat = fit_pkg::ST_ALLOC;
    if (rq.act == fit_pkg::ACT_POLL && rq.present && rq.ecat && rq.fidx == {4'd0, rq.slot})
      count_known[rq.slot] = 1'b1;
    pending_beats.push_back(rq);
    queued_cnt++;
  endtask

  task automatic drain();
    while (taken_cnt != queued_cnt || due_results.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin : drive
    req_t rq;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (!s_tvalid || beat_taken) begin
        if (pending_beats.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          rq = pending_beats.pop_front();
          in_hand = rq;
          s_tvalid <= 1'b1;
          s_tdata <= {6'd0, rq.fsrc, rq.fwkc, rq.fidx, rq.ecat, rq.present, rq.fail,
                      rq.nstat, rq.slot};
          s_tuser <= rq.act;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin : watch
    fit_pkg::result_t want;
    logic             out_taken;
    cycle_no++;
    beat_taken = !rst && s_tvalid && s_tready;
    out_taken = !rst && m_tvalid && m_tready;
    if (beat_taken) begin
      forecast(in_hand, want);
      due_results.push_back(want);
      taken_cnt++;
    end
    if (out_taken) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata[15:0], 16'd0);
      end else begin
        want = due_results.pop_front();
        if (m_tuser !== want.kind)
          report_mismatch("kind", {13'd0, m_tuser}, {13'd0, want.kind});
        if (m_tdata[15:0] !== want.value)
          report_mismatch("value", m_tdata[15:0], want.value);
        if (m_tdata[31:16] !== want.route_word)
          report_mismatch("route word", m_tdata[31:16], want.route_word);
        if (want.kind <= fit_pkg::K_OTHER)
          kind_seen[want.kind]++;
      end
      checked_cnt++;
    end
    stall_cycles = (beat_taken || out_taken || rst) ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles with no beat", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    req_t       rq;
    logic [3:0] s;
    logic [3:0] t;
    int         pick;
    for (int i = 0; i < SLOTS; i++) begin
      slot_state[i] = fit_pkg::ST_EMPTY;
      slot_count[i] = '0;
      slot_mac[i] = '0;
      count_known[i] = 1'b0;
    end
    for (int i = 0; i < 5; i++)
      kind_seen[i] = 0;
    last_granted = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // fill the whole table, then allocate once more with no slot free
    for (int i = 0; i <= SLOTS; i++) begin
      rq = random_req();
      rq.act = fit_pkg::ACT_ALLOC;
      queue_beat(rq);
    end
    // odd status codes, good and failed sends
    rq = random_req(); rq.act = fit_pkg::ACT_SET;
    rq.slot = 4'd5; rq.nstat = 3'd7; queue_beat(rq);
    rq = random_req(); rq.act = fit_pkg::ACT_SET;
    rq.slot = 4'd6; rq.nstat = 3'd5; queue_beat(rq);
    rq = random_req(); rq.act = fit_pkg::ACT_TX;
    rq.slot = 4'd2; rq.fail = 1'b0; queue_beat(rq);
    rq = random_req(); rq.act = fit_pkg::ACT_TX;
    rq.slot = 4'd4; rq.fail = 1'b1; queue_beat(rq);
    // no frame, foreign ethertype, early receive for another slot
    rq = random_req(); rq.act = fit_pkg::ACT_POLL;
    rq.slot = 4'd9; rq.present = 1'b0; queue_beat(rq);
    rq = random_req(); rq.act = fit_pkg::ACT_POLL; rq.slot = 4'd9; rq.present = 1'b1;
    rq.ecat = 1'b0; rq.fidx = 8'd2; queue_beat(rq);
    rq = random_req(); rq.act = fit_pkg::ACT_POLL; rq.slot = 4'd9; rq.present = 1'b1;
    rq.ecat = 1'b1; rq.fidx = 8'd2; rq.fwkc = 16'hffff; rq.fsrc = 16'hffff; queue_beat(rq);
    // stored counter wins over the offered frame
    rq = random_req(); rq.act = fit_pkg::ACT_POLL; rq.slot = 4'd2; rq.present = 1'b1;
    rq.ecat = 1'b1; rq.fidx = 8'd2; queue_beat(rq);
    // matching frame, index beyond the table, received set by hand
    rq = random_req(); rq.act = fit_pkg::ACT_POLL; rq.slot = 4'd15; rq.present = 1'b1;
    rq.ecat = 1'b1; rq.fidx = 8'd15; rq.fwkc = 16'h0000; rq.fsrc = 16'h0000; queue_beat(rq);
    rq = random_req(); rq.act = fit_pkg::ACT_POLL; rq.slot = 4'd9; rq.present = 1'b1;
    rq.ecat = 1'b1; rq.fidx = 8'd200; queue_beat(rq);
    rq = random_req(); rq.act = fit_pkg::ACT_SET;
    rq.slot = 4'd15; rq.nstat = fit_pkg::ST_RCVD; queue_beat(rq);
    rq = random_req(); rq.act = fit_pkg::ACT_POLL; rq.slot = 4'd15; queue_beat(rq);
    drain();

    for (int half = 0; half < 2; half++) begin
      while (queued_cnt < 30 + 700 * (half + 1)) begin
        pick = $urandom_range(0, 99);
        s = 4'($urandom_range(0, 15));
        t = s + 4'($urandom_range(1, 15));
        if (pick < 30) begin
          // allocate, send, answered by its own frame
          rq = random_req(); rq.act = fit_pkg::ACT_ALLOC; queue_beat(rq);
          rq = random_req(); rq.act = fit_pkg::ACT_TX; rq.slot = s;
          rq.fail = ($urandom_range(0, 7) == 0); queue_beat(rq);
          rq = random_req(); rq.act = fit_pkg::ACT_POLL; rq.slot = s; rq.present = 1'b1;
          rq.ecat = 1'b1; rq.fidx = {4'd0, s}; queue_beat(rq);
        end else if (pick < 50) begin
          // frame for t turns up while waiting on s
          rq = random_req(); rq.act = fit_pkg::ACT_TX; rq.slot = s;
          rq.fail = 1'b0; queue_beat(rq);
          rq = random_req(); rq.act = fit_pkg::ACT_TX; rq.slot = t;
          rq.fail = 1'b0; queue_beat(rq);
          rq = random_req(); rq.act = fit_pkg::ACT_POLL; rq.slot = s; rq.present = 1'b1;
          rq.ecat = 1'b1; rq.fidx = {4'd0, t}; queue_beat(rq);
          rq = random_req(); rq.act = fit_pkg::ACT_POLL; rq.slot = t; queue_beat(rq);
          rq = random_req(); rq.act = fit_pkg::ACT_POLL; rq.slot = s; rq.present = 1'b1;
          rq.ecat = 1'b1; rq.fidx = {4'd0, s}; queue_beat(rq);
        end else if (pick < 65) begin
          rq = random_req(); rq.act = fit_pkg::ACT_POLL; queue_beat(rq);
        end else if (pick < 80) begin
          rq = random_req(); rq.act = fit_pkg::ACT_SET; queue_beat(rq);
        end else begin
          queue_beat(random_req());
        end
      end
      // sender holds off until every result is back
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    while (due_results.size() > 0) begin
      report_mismatch("missing beat", 16'd0, due_results[0].value);
      void'(due_results.pop_front());
    end
    $display("%0d request beats, %0d result beats checked, %0d errors",
             taken_cnt, checked_cnt, errors);
    $display("kinds seen: index %0d, done %0d, counter %0d, no frame %0d, other %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/fit_pkg.sv
sv/fit_stat_mem.sv
sv/fit_data_mem.sv
sv/fit_ctrl.sv
sv/frame_index_tracker.sv
tb/frame_index_tracker_test.sv
